[src/lzwd_pkg.sv]
// Shared constants, token codes and controller/datapath handshake structs for the
// LZSS window decompressor. No dependencies.
`timescale 1ns / 1ps

package lzwd_pkg;

    // Ring window geometry.
    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);

    // Write position after reset.
    localparam logic [WIN_AW-1:0] WRITE_START = WIN_AW'(4078);

    // A reference length field is biased by this amount.
    localparam int LEN_BIAS = 3;
    localparam int CNT_W    = 5;

    // Flags per flag byte.
    localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

    // Meaning of the next payload byte.
    typedef enum logic [1:0] {
        TOK_FLAG,
        TOK_LITERAL,
        TOK_REF_HIGH,
        TOK_REF_LOW
    } t_tok;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load_flag;
        logic load_high;
        logic put_lit;
        logic start_copy;
        logic rd_issue;
        logic put_copy;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_tok tok;
        logic clr_last;
        logic out_free;
        logic copy_last;
    } t_status;

endpackage

[src/lzwd_in_if.sv]
// Input byte channel: valid/ready handshake carrying one compressed byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[src/lzwd_out_if.sv]
// Output byte channel: valid/ready handshake carrying one decompressed byte
// and the flag that marks the last byte of a run. Depends on nothing.
`timescale 1ns / 1ps

interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[src/lzwd_ctrl.sv]
// Controller state machine: window clearing, token dispatch and the copy loop.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lzwd_pkg::t_status i_status,
    output lzwd_pkg::t_cmd    o_cmd
);
    import lzwd_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // A new request is taken only in idle with room in the output register.
    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Command decode and next state.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_status.tok)
                        TOK_FLAG:     o_cmd.load_flag = 1'b1;
                        TOK_LITERAL:  o_cmd.put_lit   = 1'b1;
                        TOK_REF_HIGH: o_cmd.load_high = 1'b1;
                        TOK_REF_LOW: begin
                            o_cmd.start_copy = 1'b1;
                            n_state          = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.put_copy = 1'b1;
                    n_state        = i_status.copy_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register; reset starts the window clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/lzwd_datapath.sv]
// Datapath: token state, ring window memory, copy pointer and output register.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_in_byte,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    input  lzwd_pkg::t_cmd    i_cmd,
    output lzwd_pkg::t_status o_status
);
    import lzwd_pkg::*;

    logic [7:0]        r_flag_bits;
    logic [3:0]        r_flags_left;
    logic              r_phase_ref;
    logic [7:0]        r_ref_high;
    logic [WIN_AW-1:0] r_write_pos;
    logic [WIN_AW-1:0] r_rd_pos;
    logic [WIN_AW-1:0] r_clr_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic [7:0]        r_rd_data;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic [7:0]        r_window [WINDOW_SIZE];

    logic              w_we;
    logic [WIN_AW-1:0] w_wa;
    logic [7:0]        w_wd;
    logic              w_put;
    logic [15:0]       w_ref_val;
    t_tok              w_tok;

    assign w_ref_val = {r_ref_high, i_in_byte};

    // Classify the next payload byte from the token state.
    always_comb begin
        priority if (r_phase_ref) begin
            w_tok = TOK_REF_LOW;
        end else if (r_flags_left == 4'd0) begin
            w_tok = TOK_FLAG;
        end else if (r_flag_bits[0]) begin
            w_tok = TOK_LITERAL;
        end else begin
            w_tok = TOK_REF_HIGH;
        end
    end

    assign o_status.tok       = w_tok;
    assign o_status.clr_last  = (r_clr_addr == {WIN_AW{1'b1}});
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.copy_last = (r_cnt == CNT_W'(1));

    // Window write port: clearing pass, literal or copied byte.
    assign w_put = i_cmd.put_lit || i_cmd.put_copy;
    assign w_we  = i_cmd.clr_step || w_put;
    assign w_wa  = i_cmd.clr_step ? r_clr_addr : r_write_pos;
    assign w_wd  = i_cmd.clr_step ? 8'd0 : (i_cmd.put_lit ? i_in_byte : r_rd_data);

    // Ring window memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_window[w_wa] <= w_wd;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_window[r_rd_pos];
        end
    end

    // Token state, pointers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bits  <= 8'd0;
            r_flags_left <= 4'd0;
            r_phase_ref  <= 1'b0;
            r_ref_high   <= 8'd0;
            r_write_pos  <= WRITE_START;
            r_clr_addr   <= '0;
            r_cnt        <= '0;
            r_rd_pos     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + WIN_AW'(1);
            end
            if (i_cmd.load_flag) begin
                r_flag_bits  <= i_in_byte;
                r_flags_left <= FLAGS_PER_BYTE;
            end
            if (i_cmd.load_high) begin
                r_ref_high  <= i_in_byte;
                r_phase_ref <= 1'b1;
            end
            // A literal or the start of a copy consumes one flag bit.
            if (i_cmd.put_lit || i_cmd.start_copy) begin
                r_flag_bits  <= {1'b0, r_flag_bits[7:1]};
                r_flags_left <= r_flags_left - 4'd1;
            end
            if (i_cmd.start_copy) begin
                r_phase_ref <= 1'b0;
                r_rd_pos    <= w_ref_val[15:4];
                r_cnt       <= CNT_W'(w_ref_val[3:0]) + CNT_W'(LEN_BIAS);
            end
            if (i_cmd.rd_issue) begin
                r_rd_pos <= r_rd_pos + WIN_AW'(1);
            end
            if (i_cmd.put_copy) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (w_put) begin
                r_write_pos <= r_write_pos + WIN_AW'(1);
            end
            // Output register holds until the sink takes the request.
            if (w_put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_out_byte <= w_wd;
            r_out_last <= i_cmd.put_lit || o_status.copy_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

[src/lzwd_window_decompressor_core.sv]
`timescale 1ns / 1ps
// LZSS decompressor with a 4096-byte ring window. Compressed bytes come in one per
// request; a flag byte precedes every group of eight tokens (bit set: literal, bit
// clear: two-byte reference of 12-bit position and 4-bit length plus three). After
// reset the window is cleared one byte a cycle, and no input is taken meanwhile.
// Flag and reference high bytes update the token state; a literal yields one output
// byte. A reference low byte then yields 3 to 18 bytes, each by a registered window
// read and then a window write and output load that waits out any output stall;
// each read waits for the write before it, as a copy may read a byte it just wrote.
// last_of_run marks the final byte produced by each input byte.
// Depends on lzwd_pkg, lzwd_in_if, lzwd_out_if, lzwd_ctrl and lzwd_datapath.

module lzss_window_decompressor_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzwd_in_if.sink    i_in,
    lzwd_out_if.source o_out
);
    import lzwd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer for clearing, token dispatch and the copy loop.
    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Window memory, token state and output register.
    lzwd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_in.in_byte),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last_of_run),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

[dv/lzwd_stream_monitor.sv]
`timescale 1ns / 1ps
// Stream monitor for the LZSS window decompressor: follows both byte channels, decodes
// the accepted compressed bytes itself and compares every output byte. Depends on lzwd_pkg.

module lzwd_stream_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    import lzwd_pkg::*;

    // Where the decoder stands between two compressed bytes.
    typedef enum logic [1:0] {
        PH_TOKEN_START,
        PH_REF_LOW
    } t_parse_phase;

    // One decompressed byte as it should leave the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    // Decoder state, mirrored from the block's behavior.
    logic [7:0]        flag_reg;
    logic [3:0]        flags_remaining;
    t_parse_phase      parse_phase;
    logic [7:0]        ref_high;
    logic [7:0]        window_mem [WINDOW_SIZE];
    logic [WIN_AW-1:0] wr_ptr;

    t_out_beat expected_bytes [$];
    t_out_beat head_beat;
    int        fail_total;
    int        checked_total;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    // Every produced byte lands in the ring window and in the expected stream.
    task automatic emit_byte(input logic [7:0] data, input logic last);
        t_out_beat beat;
        window_mem[wr_ptr] = data;
        wr_ptr = wr_ptr + WIN_AW'(1);
        beat = t_out_beat'{data: data, last: last};
        expected_bytes = {expected_bytes, beat};
    endtask

    task automatic use_flag();
        flag_reg = flag_reg >> 1;
        flags_remaining = flags_remaining - 4'd1;
    endtask

    // Decode one accepted compressed byte and queue the bytes it produces.
    task automatic decode_byte(input logic [7:0] b);
        logic [15:0]       token;
        logic [WIN_AW-1:0] src;
        int                len;
        if (parse_phase == PH_REF_LOW) begin
            token = {ref_high, b};
            len = int'(token[3:0]) + LEN_BIAS;
            src = token[15:4];
            // Byte by byte, so a copy may read what it has just written.
            for (int i = 0; i < len; i++) begin
                emit_byte(window_mem[src], i == len - 1);
                src = src + WIN_AW'(1);
            end
            use_flag();
            parse_phase = PH_TOKEN_START;
        end else if (flags_remaining == 4'd0) begin
            flag_reg = b;
            flags_remaining = FLAGS_PER_BYTE;
        end else if (flag_reg[0]) begin
            emit_byte(b, 1'b1);
            use_flag();
        end else begin
            ref_high = b;
            parse_phase = PH_REF_LOW;
        end
    endtask

    // Output requests are checked before the input request of the same edge is decoded.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flag_reg = '0;
            flags_remaining = '0;
            parse_phase = PH_TOKEN_START;
            ref_high = '0;
            wr_ptr = WRITE_START;
            for (int k = 0; k < WINDOW_SIZE; k++) begin
                window_mem[k] = '0;
            end
            expected_bytes.delete();
            fail_total = 0;
            checked_total = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("output byte 0x%02h with nothing expected",
                                              i_out_byte));
                end else begin
                    head_beat = expected_bytes.pop_front();
                    checked_total++;
                    if (i_out_byte !== head_beat.data) begin
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  i_out_byte, head_beat.data));
                    end
                    if (i_out_last !== head_beat.last) begin
                        report_mismatch($sformatf("last_of_run %0b, expected %0b on byte 0x%02h",
                                                  i_out_last, head_beat.last, head_beat.data));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_byte);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_bytes.size();
        o_checked    <= checked_total;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Top of the LZSS window decompressor testbench: clock, reset, compressed stimulus,
// output back-pressure and the verdict. Depends on lzwd_pkg, both channel interfaces,
// lzss_window_decompressor_core and lzwd_stream_monitor.

module tb;
    import lzwd_pkg::*;

    localparam int CLK_PERIOD_NS  = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_GAP        = 8;
    localparam int ITEM_TARGET    = 370;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TIMEOUT_CYCLES = 500_000;

    logic i_clk;
    logic i_rst_n;

    lzwd_in_if  in_ch ();
    lzwd_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;

    // Shared between the sender and the receiver processes.
    bit burst_mode;
    bit hold_off_req;

    // Sender bookkeeping: where the next produced byte will land in the window.
    logic [WIN_AW-1:0] stream_pos;
    int bytes_sent;
    int literal_count;
    int ref_count;

    lzss_window_decompressor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzwd_stream_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_byte    (in_ch.in_byte),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_byte   (out_ch.out_byte),
        .i_out_last   (out_ch.last_of_run),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    // Offer one compressed byte after a random gap (none in burst mode) and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_literal(input logic [7:0] b);
        send_byte(b);
        stream_pos = stream_pos + WIN_AW'(1);
        literal_count++;
    endtask

    // A reference goes out as two big-endian bytes: upper position bits, then low position bits and biased length.
    task automatic send_ref(input logic [WIN_AW-1:0] pos, input int len);
        logic [15:0] token;
        token = {pos, 4'(len - LEN_BIAS)};
        send_byte(token[15:8]);
        send_byte(token[7:0]);
        stream_pos = stream_pos + WIN_AW'(len);
        ref_count++;
    endtask

    // Output side: random stalls, a no-stall stretch and one long hold-off.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Run limit.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
        $display("FAILURE");
        $finish;
    end

    // Reset, stimulus and verdict.
    initial begin
        logic [7:0]        flags;
        logic [WIN_AW-1:0] pos;
        int                len;
        int                group;
        int                pick;

        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        i_rst_n       <= 1'b0;
        burst_mode    = 1'b0;
        hold_off_req  = 1'b0;
        stream_pos    = WRITE_START;
        bytes_sent    = 0;
        literal_count = 0;
        ref_count     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed group: extreme literals, then an overlapping copy from the start
        // position, a minimum copy from position zero, a maximum copy that wraps the
        // window, and a distance-one copy that repeats a single byte.
        send_byte(8'h0F);
        send_literal(8'h00);
        send_literal(8'hFF);
        send_literal(8'hA5);
        send_literal(8'h5A);
        send_ref(WRITE_START, 18);
        send_ref('0, 3);
        send_ref('1, 18);
        send_ref(stream_pos - WIN_AW'(1), 18);

        // Directed group: all literals, walking one.
        send_byte(8'hFF);
        for (int i = 0; i < 8; i++) begin
            send_literal(8'(1 << i));
        end

        // Random groups: literals and references, mostly into recent output.
        group = 0;
        while (bytes_sent < ITEM_TARGET - 2) begin
            if (group == 6) begin
                hold_off_req = 1'b1;
            end
            burst_mode = (group >= 14 && group < 20);
            flags = 8'($urandom_range(0, 255));
            send_byte(flags);
            for (int i = 0; i < 8; i++) begin
                if (flags[i]) begin
                    send_literal(8'($urandom_range(0, 255)));
                end else begin
                    len = $urandom_range(LEN_BIAS, LEN_BIAS + 15);
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        pos = stream_pos - WIN_AW'($urandom_range(1, 32));
                    end else if (pick < 9) begin
                        pos = WIN_AW'($urandom_range(0, WINDOW_SIZE - 1));
                    end else begin
                        // Reads the byte that the copy itself overwrites first.
                        pos = stream_pos;
                    end
                    send_ref(pos, len);
                end
            end
            group++;
        end
        burst_mode = 1'b0;

        // A truncated reference at the end must produce nothing.
        send_byte(8'h00);
        send_byte(8'h12);
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d compressed bytes: %0d literals and %0d references,",
                 bytes_sent, literal_count, ref_count);
        $display("with %0d decompressed bytes compared under random stalls and a long hold-off.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[lzss_window_decompressor_core.f]
src/lzwd_pkg.sv
src/lzwd_in_if.sv
src/lzwd_out_if.sv
src/lzwd_ctrl.sv
src/lzwd_datapath.sv
src/lzwd_window_decompressor_core.sv
dv/lzwd_stream_monitor.sv
dv/tb.sv
